// File: rtl/core/waveform_minmax_decimator_unit_defines.svh
// Assertion macros shared by the waveform min/max decimator RTL.
`ifndef WAVEFORM_MINMAX_DECIMATOR_UNIT_DEFINES_SVH
`define WAVEFORM_MINMAX_DECIMATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every clock out of reset.
`define WMD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock out of reset.
`define WMD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/wmd_pkg.sv
// Shared types and constants of the waveform min/max decimator.
`timescale 1ns / 1ps
package wmd_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_GROUP_SIZE    = 3'd0;
    localparam logic [2:0] REG_SCALE_FACTOR  = 3'd1;
    localparam logic [2:0] REG_CENTER_ROW    = 3'd2;
    localparam logic [2:0] REG_SAMPLE_FORMAT = 3'd3;
    localparam logic [2:0] REG_COLUMN_LIMIT  = 3'd4;

    // Sample format codes
    localparam logic [1:0] FMT_U8_OFS  = 2'd0;
    localparam logic [1:0] FMT_S16     = 2'd1;
    localparam logic [1:0] FMT_S32     = 2'd2;
    localparam logic [1:0] FMT_S64     = 2'd3;

    // Offset removed from 8-bit unsigned samples
    localparam logic signed [64:0] U8_OFFSET = 65'sd127;

    // Reset values of the configuration registers
    localparam logic [15:0] GROUP_SIZE_RST    = 16'd1;
    localparam logic [31:0] SCALE_FACTOR_RST  = 32'd65536;
    localparam logic [14:0] CENTER_ROW_RST    = 15'd0;
    localparam logic [1:0]  SAMPLE_FORMAT_RST = FMT_S16;
    localparam logic [15:0] COLUMN_LIMIT_RST  = 16'd640;

    // Scaled product word handed from the multiplier stage to the fold stage
    typedef struct packed {
        logic        valid;
        logic [47:0] quot;   // product >> 16
        logic        neg;    // sample was negative
        logic        ovf;    // magnitude above 32 bits with nonzero gain
        logic        last;   // data end marker
    } wmd_prod_t;

    // Column close request from the fold stage to the output queue
    typedef struct packed {
        logic        fire;   // push this cycle
        logic        two;    // two points (max, min) instead of one
        logic [15:0] col;
    } wmd_push_t;

endpackage

// File: rtl/core/wmd_front.sv
// Input register, sample decode and Q16.16 gain multiply.
`timescale 1ns / 1ps
module wmd_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [63:0]         raw_sample,
    input  logic                data_end,
    input  logic [1:0]          sample_format,
    input  logic [31:0]         scale_factor,
    input  logic                fold_fire,
    output wmd_pkg::wmd_prod_t  prod
);

    logic               v1_reg;
    logic               v1_next;
    logic [63:0]        mag_reg;
    logic               neg_reg;
    logic               end_reg;
    wmd_pkg::wmd_prod_t p_reg;
    wmd_pkg::wmd_prod_t p_next;

    logic signed [64:0] dec;
    logic [64:0]        mag_full;
    logic               accept;
    logic               adv2;
    logic [63:0]        product;

    // Decode the raw word into a signed value and take its magnitude
    always_comb
    begin
        unique case (sample_format)
            wmd_pkg::FMT_U8_OFS: dec = $signed({57'd0, raw_sample[7:0]}) - wmd_pkg::U8_OFFSET;
            wmd_pkg::FMT_S16:    dec = $signed({{49{raw_sample[15]}}, raw_sample[15:0]});
            wmd_pkg::FMT_S32:    dec = $signed({{33{raw_sample[31]}}, raw_sample[31:0]});
            default:             dec = $signed({raw_sample[63], raw_sample});
        endcase
        mag_full = dec[64] ? 65'(-dec) : 65'(dec);
    end

    // Stage handshake: stage 2 moves when empty or consumed by the fold
    assign adv2     = !p_reg.valid || fold_fire;
    assign in_stall = v1_reg && !adv2;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
            v1_next = 1'b1;
        else if (adv2)
            v1_next = 1'b0;
        else
            v1_next = v1_reg;
    end

    // Gain multiply, one 32x32 product
    assign product = {32'd0, mag_reg[31:0]} * {32'd0, scale_factor};

    always_comb
    begin
        p_next = p_reg;
        if (adv2)
        begin
            p_next.valid = v1_reg;
            p_next.quot  = product[63:16];
            p_next.neg   = neg_reg;
            p_next.ovf   = (mag_reg[63:32] != 32'd0) && (scale_factor != 32'd0);
            p_next.last  = end_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            p_reg  <= '0;
        end
        else
        begin
            v1_reg <= v1_next;
            p_reg  <= p_next;
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mag_reg <= mag_full[63:0];
            neg_reg <= dec[64];
            end_reg <= data_end;
        end
    end

    assign prod = p_reg;

endmodule

// File: rtl/core/wmd_fold.sv
// Saturation of the scaled value and per-column min/max fold.
`timescale 1ns / 1ps
module wmd_fold
#(
    parameter int ROW_WIDTH = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  wmd_pkg::wmd_prod_t         prod,
    input  logic                       room,
    input  logic [15:0]                group_size,
    input  logic [15:0]                column_limit,
    output logic                       fold_fire,
    output wmd_pkg::wmd_push_t         push,
    output logic signed [ROW_WIDTH:0]  first_val,
    output logic signed [ROW_WIDTH:0]  second_val
);

    localparam logic [47:0] POS_LIM = (48'd1 << ROW_WIDTH) - 48'd1;
    localparam logic [47:0] NEG_LIM = 48'd1 << ROW_WIDTH;

    logic signed [ROW_WIDTH:0] min_reg, min_next;
    logic signed [ROW_WIDTH:0] max_reg, max_next;
    logic [15:0]               gc_reg, gc_next;
    logic [15:0]               col_reg, col_next;

    logic [ROW_WIDTH:0]        q_sat;
    logic signed [ROW_WIDTH:0] s;
    logic signed [ROW_WIDTH:0] min_new;
    logic signed [ROW_WIDTH:0] max_new;
    logic [15:0]               gc_new;
    logic                      drop;
    logic                      close;
    logic                      two;

    assign fold_fire = prod.valid && room;

    // Clamp the magnitude to the state range and restore the sign
    always_comb
    begin
        if (prod.neg)
        begin
            if (prod.ovf || (prod.quot > NEG_LIM))
                q_sat = NEG_LIM[ROW_WIDTH:0];
            else
                q_sat = prod.quot[ROW_WIDTH:0];
        end
        else
        begin
            if (prod.ovf || (prod.quot > POS_LIM))
                q_sat = POS_LIM[ROW_WIDTH:0];
            else
                q_sat = prod.quot[ROW_WIDTH:0];
        end
        s = prod.neg ? -$signed(q_sat) : $signed(q_sat);
    end

    // Fold and column close decision
    always_comb
    begin
        drop    = col_reg >= column_limit;
        min_new = (s < min_reg) ? s : min_reg;
        max_new = (s > max_reg) ? s : max_reg;
        gc_new  = gc_reg + 16'd1;
        close   = !drop && ((gc_new >= group_size) || prod.last);
        two     = close && (min_new != '0) && (max_new != '0);

        push.fire  = fold_fire && close;
        push.two   = two;
        push.col   = col_reg;
        first_val  = two ? max_new : s;
        second_val = min_new;
    end

    // State update
    always_comb
    begin
        min_next = min_reg;
        max_next = max_reg;
        gc_next  = gc_reg;
        col_next = col_reg;
        if (fold_fire)
        begin
            if (!drop)
            begin
                min_next = min_new;
                max_next = max_new;
                gc_next  = gc_new;
                if (close)
                    col_next = col_reg + 16'd1;
            end
            if (close || prod.last)
            begin
                min_next = '0;
                max_next = '0;
                gc_next  = '0;
            end
            if (prod.last)
                col_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= '0;
            max_reg <= '0;
            gc_reg  <= '0;
            col_reg <= '0;
        end
        else
        begin
            min_reg <= min_next;
            max_reg <= max_next;
            gc_reg  <= gc_next;
            col_reg <= col_next;
        end
    end

endmodule

// File: rtl/core/wmd_outq.sv
// Four-entry point queue with row offset and saturation on the read side.
`timescale 1ns / 1ps
`include "waveform_minmax_decimator_unit_defines.svh"
module wmd_outq
#(
    parameter int ROW_WIDTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  wmd_pkg::wmd_push_t            push,
    input  logic signed [ROW_WIDTH:0]     first_val,
    input  logic signed [ROW_WIDTH:0]     second_val,
    input  logic [14:0]                   center_row,
    output logic                          room,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [ROW_WIDTH-1:0]   point_row,
    output logic [15:0]                   column_index,
    output logic                          last_point
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = (ROW_WIDTH + 2 > 17) ? ROW_WIDTH + 2 : 17;
    localparam logic signed [SW-1:0] ROW_HI = SW'((64'd1 << (ROW_WIDTH - 1)) - 64'd1);
    localparam logic signed [SW-1:0] ROW_LO = -ROW_HI - SW'(1);

    logic signed [ROW_WIDTH:0] val_mem [DEPTH];
    logic [15:0]               col_mem [DEPTH];
    logic                      last_mem [DEPTH];

    logic [AW-1:0] wr_reg, wr_next;
    logic [AW-1:0] rd_reg, rd_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic [AW-1:0] wr_plus1;
    logic [AW:0]   push_n;
    logic          pop;

    logic signed [SW-1:0] row_sum;

    // Flow control: a close pushes at most two points
    assign room      = cnt_reg <= (AW+1)'(DEPTH - 2);
    assign out_valid = cnt_reg != '0;
    assign pop       = out_valid && !out_stall;
    assign wr_plus1  = wr_reg + AW'(1);

    always_comb
    begin
        push_n = '0;
        if (push.fire)
            push_n = push.two ? (AW+1)'(2) : (AW+1)'(1);
        wr_next  = wr_reg + push_n[AW-1:0];
        rd_next  = pop ? rd_reg + AW'(1) : rd_reg;
        cnt_next = cnt_reg + push_n - (AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push.fire)
        begin
            val_mem[wr_reg]  <= first_val;
            col_mem[wr_reg]  <= push.col;
            last_mem[wr_reg] <= !push.two;
            if (push.two)
            begin
                val_mem[wr_plus1]  <= second_val;
                col_mem[wr_plus1]  <= push.col;
                last_mem[wr_plus1] <= 1'b1;
            end
        end
    end

    // Head word: center row plus value, saturated to the row width
    always_comb
    begin
        row_sum = $signed(SW'({1'b0, center_row})) + SW'(val_mem[rd_reg]);
        if (row_sum > ROW_HI)
            row_sum = ROW_HI;
        else if (row_sum < ROW_LO)
            row_sum = ROW_LO;
        point_row    = row_sum[ROW_WIDTH-1:0];
        column_index = col_mem[rd_reg];
        last_point   = last_mem[rd_reg];
    end

    `WMD_ASSERT_IMP(a_cnt_range, 1'b1, cnt_reg <= (AW+1)'(DEPTH), "point queue count out of range")
    `WMD_ASSERT_IMP(a_push_room, push.fire, room, "point pushed without room for two")
    `WMD_ASSERT_NXT(a_pop_only, pop && !push.fire, cnt_reg == $past(cnt_reg) - (AW+1)'(1), "pop did not drop count")
    `WMD_ASSERT_NXT(a_push_two, push.fire && push.two && !pop, cnt_reg == $past(cnt_reg) + (AW+1)'(2), "pair push lost a point")

endmodule

// File: rtl/core/waveform_minmax_decimator_unit.sv
// Top level of the waveform min/max decimator: config registers and pipeline.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------
//  in      | sink      | in_valid / in_stall   | raw_sample, data_end
//  out     | source    | out_valid / out_stall | point_row, column_index, last_point
//  cfg     | sink      | cfg_write             | cfg_index, cfg_data
//
// One sample per cycle while in_stall is low; its points reach the queue head through the
// input register, the multiply register and the fold into the queue, in that order.
// Columns that close with a pair on every sample slow the input, as the queue pops one point at a time.
// The fold holds while the four-entry point queue has fewer than two free slots;
// in_stall rises once both registers ahead of the fold hold words and the fold does not fire.
// Reset is asynchronous, active low, and clears all control and column state.
`timescale 1ns / 1ps
module waveform_minmax_decimator_unit
#(
    parameter int ROW_WIDTH = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [2:0]                  cfg_index,
    input  logic [31:0]                 cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [63:0]                 raw_sample,
    input  logic                        data_end,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [ROW_WIDTH-1:0] point_row,
    output logic [15:0]                 column_index,
    output logic                        last_point
);

    logic [15:0] group_size_reg;
    logic [31:0] scale_factor_reg;
    logic [14:0] center_row_reg;
    logic [1:0]  sample_format_reg;
    logic [15:0] column_limit_reg;

    wmd_pkg::wmd_prod_t        prod;
    wmd_pkg::wmd_push_t        push;
    logic                      fold_fire;
    logic                      room;
    logic signed [ROW_WIDTH:0] first_val;
    logic signed [ROW_WIDTH:0] second_val;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_size_reg    <= wmd_pkg::GROUP_SIZE_RST;
            scale_factor_reg  <= wmd_pkg::SCALE_FACTOR_RST;
            center_row_reg    <= wmd_pkg::CENTER_ROW_RST;
            sample_format_reg <= wmd_pkg::SAMPLE_FORMAT_RST;
            column_limit_reg  <= wmd_pkg::COLUMN_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                wmd_pkg::REG_GROUP_SIZE:    group_size_reg    <= cfg_data[15:0];
                wmd_pkg::REG_SCALE_FACTOR:  scale_factor_reg  <= cfg_data;
                wmd_pkg::REG_CENTER_ROW:    center_row_reg    <= cfg_data[14:0];
                wmd_pkg::REG_SAMPLE_FORMAT: sample_format_reg <= cfg_data[1:0];
                wmd_pkg::REG_COLUMN_LIMIT:  column_limit_reg  <= cfg_data[15:0];
                default:                    ;
            endcase
        end
    end

    // Decode and multiply
    wmd_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .raw_sample    (raw_sample),
        .data_end      (data_end),
        .sample_format (sample_format_reg),
        .scale_factor  (scale_factor_reg),
        .fold_fire     (fold_fire),
        .prod          (prod)
    );

    // Min/max fold
    wmd_fold #(.ROW_WIDTH(ROW_WIDTH)) u_fold
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .prod         (prod),
        .room         (room),
        .group_size   (group_size_reg),
        .column_limit (column_limit_reg),
        .fold_fire    (fold_fire),
        .push         (push),
        .first_val    (first_val),
        .second_val   (second_val)
    );

    // Point queue and output
    wmd_outq #(.ROW_WIDTH(ROW_WIDTH)) u_outq
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .first_val    (first_val),
        .second_val   (second_val),
        .center_row   (center_row_reg),
        .room         (room),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .point_row    (point_row),
        .column_index (column_index),
        .last_point   (last_point)
    );

endmodule
